// ===== src/awcs_pkg.sv =====
// Shared types and constants for the area-weighted CDF sampler.
// Used by awcs_geom, area_weighted_cdf_sampler and awcs_checker; no dependencies.
package awcs_pkg;

   // Default number of table entries.
   localparam int DEFAULT_TABLE_DEPTH = 1024;

   localparam int COORD_W  = 16;
   localparam int AREA_W   = 35;   // floor(sqrt(S)) >> 1, S < 2^70
   localparam int ROOT_W   = 36;
   localparam int CUM_W    = 48;
   localparam int NRM_W    = 48;   // packed {z,y,x}, Q1.15 each
   localparam int MINA_W   = 36;
   localparam int INDEX_W  = 10;   // width of the entry_index field
   localparam int STATUS_W = 3;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_SKIPPED  = 3'd1,
      ST_FULL     = 3'd2,
      ST_SAMPLED  = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   // Item modes.
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   // Top level sequencer.
   typedef enum logic [2:0] {
      T_IDLE,
      T_GEOM,
      T_DART,
      T_SEARCH,
      T_COMPARE,
      T_LOAD,
      T_OUT
   } top_state_type;

   // Geometry unit sequencer.
   typedef enum logic [2:0] {
      G_IDLE,
      G_CROSS,
      G_SQUARE,
      G_SQRT,
      G_DLOAD,
      G_DIV,
      G_DSTORE,
      G_DONE
   } geom_state_type;

   // Triangle handed to the geometry unit.
   typedef struct packed {
      logic signed [COORD_W-1:0] v0_x;
      logic signed [COORD_W-1:0] v0_y;
      logic signed [COORD_W-1:0] v0_z;
      logic signed [COORD_W-1:0] v1_x;
      logic signed [COORD_W-1:0] v1_y;
      logic signed [COORD_W-1:0] v1_z;
      logic signed [COORD_W-1:0] v2_x;
      logic signed [COORD_W-1:0] v2_y;
      logic signed [COORD_W-1:0] v2_z;
   } tri_type;

   // Geometry unit result, done pulses for one cycle.
   typedef struct packed {
      logic              done;
      logic [AREA_W-1:0] area;
      logic [NRM_W-1:0]  normal;
   } geom_res_type;

endpackage

// ===== src/awcs_geom.sv =====
// Triangle geometry unit: cross product and squared length on one shared 18x18 multiplier,
// then the integer square root and the three normal divisions. Uses awcs_pkg.
module awcs_geom
   import awcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  tri_type      tri_in,
   output geom_res_type result
);

   geom_state_type state_ff, state_in;

   logic signed [16:0] e1x_ff, e1y_ff, e1z_ff, e2x_ff, e2y_ff, e2z_ff;
   logic signed [34:0] cx_ff, cy_ff, cz_ff;
   logic [5:0]         step_ff;
   logic [1:0]         comp_ff;
   logic [71:0]        s_ff;
   logic [39:0]        rem_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [50:0]        n_ff, d_ff;
   logic [15:0]        q_ff;
   logic [NRM_W-1:0]   nrm_ff;

   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] prod;
   logic [33:0]        mag_x, mag_y, mag_z, mag_sel;
   logic               neg_sel;
   logic [39:0]        rem_sh;
   logic [39:0]        trial;
   logic               root_bit;
   logic               q_bit;
   logic [15:0]        q_sat;
   logic [71:0]        sq_add;

   function automatic logic [33:0] abs_mag(input logic signed [34:0] v);
      logic signed [34:0] t;
      t = (v < 0) ? -v : v;
      return t[33:0];
   endfunction

   assign mag_x = abs_mag(cx_ff);
   assign mag_y = abs_mag(cy_ff);
   assign mag_z = abs_mag(cz_ff);

   // Component under work in the square and divide phases
   always_comb begin
      unique case (comp_ff)
         2'd0:    begin mag_sel = mag_x; neg_sel = cx_ff[34]; end
         2'd1:    begin mag_sel = mag_y; neg_sel = cy_ff[34]; end
         default: begin mag_sel = mag_z; neg_sel = cz_ff[34]; end
      endcase
   end

   // Shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == G_CROSS) begin
         unique case (step_ff[2:0])
            3'd0:    begin mul_a = 18'(e1y_ff); mul_b = 18'(e2z_ff); end
            3'd1:    begin mul_a = 18'(e1z_ff); mul_b = 18'(e2y_ff); end
            3'd2:    begin mul_a = 18'(e1z_ff); mul_b = 18'(e2x_ff); end
            3'd3:    begin mul_a = 18'(e1x_ff); mul_b = 18'(e2z_ff); end
            3'd4:    begin mul_a = 18'(e1x_ff); mul_b = 18'(e2y_ff); end
            default: begin mul_a = 18'(e1y_ff); mul_b = 18'(e2x_ff); end
         endcase
      end else begin
         // squares split in 17-bit halves: lo*lo, lo*hi, hi*hi
         unique case (step_ff[1:0])
            2'd0:    begin
               mul_a = {1'b0, mag_sel[16:0]}; mul_b = {1'b0, mag_sel[16:0]};
            end
            2'd1:    begin
               mul_a = {1'b0, mag_sel[16:0]}; mul_b = {1'b0, mag_sel[33:17]};
            end
            default: begin
               mul_a = {1'b0, mag_sel[33:17]}; mul_b = {1'b0, mag_sel[33:17]};
            end
         endcase
      end
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      unique case (step_ff[1:0])
         2'd0:    sq_add = 72'(prod[33:0]);
         2'd1:    sq_add = 72'(prod[33:0]) << 18;
         default: sq_add = 72'(prod[33:0]) << 34;
      endcase
   end

   // Square root: two radicand bits per step
   assign rem_sh   = {rem_ff[37:0], s_ff[71:70]};
   assign trial    = {2'b00, root_ff, 2'b01};
   assign root_bit = (rem_sh >= trial);

   // Restoring division: one quotient bit per step
   assign q_bit = (n_ff >= d_ff);

   always_comb begin
      if (neg_sel)
         q_sat = (q_ff > 16'd32768) ? 16'h8000 : 16'(-q_ff);
      else
         q_sat = (q_ff > 16'd32767) ? 16'h7FFF : q_ff;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         G_IDLE:   if (start) state_in = G_CROSS;
         G_CROSS:  if (step_ff == 6'd5) state_in = G_SQUARE;
         G_SQUARE: if (step_ff == 6'd2 && comp_ff == 2'd2) state_in = G_SQRT;
         G_SQRT:   if (step_ff == 6'd35) state_in = G_DLOAD;
         G_DLOAD:  state_in = G_DIV;
         G_DIV:    if (step_ff == 6'd15) state_in = G_DSTORE;
         G_DSTORE: state_in = (comp_ff == 2'd2) ? G_DONE : G_DLOAD;
         G_DONE:   state_in = G_IDLE;
         default:  state_in = G_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= G_IDLE;
      else       state_ff <= state_in;
   end

   // Datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         G_IDLE: begin
            e1x_ff  <= {tri_in.v1_x[15], tri_in.v1_x} - {tri_in.v0_x[15], tri_in.v0_x};
            e1y_ff  <= {tri_in.v1_y[15], tri_in.v1_y} - {tri_in.v0_y[15], tri_in.v0_y};
            e1z_ff  <= {tri_in.v1_z[15], tri_in.v1_z} - {tri_in.v0_z[15], tri_in.v0_z};
            e2x_ff  <= {tri_in.v2_x[15], tri_in.v2_x} - {tri_in.v0_x[15], tri_in.v0_x};
            e2y_ff  <= {tri_in.v2_y[15], tri_in.v2_y} - {tri_in.v0_y[15], tri_in.v0_y};
            e2z_ff  <= {tri_in.v2_z[15], tri_in.v2_z} - {tri_in.v0_z[15], tri_in.v0_z};
            cx_ff   <= '0;
            cy_ff   <= '0;
            cz_ff   <= '0;
            step_ff <= '0;
            comp_ff <= '0;
         end
         G_CROSS: begin
            // even steps add, odd steps subtract
            unique case (step_ff[2:1])
               2'd0:    cx_ff <= step_ff[0] ? cx_ff - 35'(prod) : cx_ff + 35'(prod);
               2'd1:    cy_ff <= step_ff[0] ? cy_ff - 35'(prod) : cy_ff + 35'(prod);
               default: cz_ff <= step_ff[0] ? cz_ff - 35'(prod) : cz_ff + 35'(prod);
            endcase
            step_ff <= (step_ff == 6'd5) ? 6'd0 : step_ff + 6'd1;
            s_ff    <= '0;
         end
         G_SQUARE: begin
            s_ff <= s_ff + sq_add;
            if (step_ff == 6'd2) begin
               step_ff <= '0;
               comp_ff <= comp_ff + 2'd1;
            end else begin
               step_ff <= step_ff + 6'd1;
            end
            rem_ff  <= '0;
            root_ff <= '0;
         end
         G_SQRT: begin
            rem_ff  <= root_bit ? rem_sh - trial : rem_sh;
            root_ff <= {root_ff[ROOT_W-2:0], root_bit};
            s_ff    <= s_ff << 2;
            step_ff <= (step_ff == 6'd35) ? 6'd0 : step_ff + 6'd1;
            comp_ff <= '0;
         end
         G_DLOAD: begin
            n_ff    <= 51'({mag_sel, 15'd0}) + 51'(root_ff >> 1);
            d_ff    <= 51'({root_ff, 15'd0});
            q_ff    <= '0;
            step_ff <= '0;
         end
         G_DIV: begin
            if (q_bit) n_ff <= n_ff - d_ff;
            d_ff    <= d_ff >> 1;
            q_ff    <= {q_ff[14:0], q_bit};
            step_ff <= step_ff + 6'd1;
         end
         G_DSTORE: begin
            unique case (comp_ff)
               2'd0:    nrm_ff[15:0]  <= q_sat;
               2'd1:    nrm_ff[31:16] <= q_sat;
               default: nrm_ff[47:32] <= q_sat;
            endcase
            comp_ff <= comp_ff + 2'd1;
         end
         default: begin
            step_ff <= '0;
         end
      endcase
   end

   assign result.done   = (state_ff == G_DONE);
   assign result.area   = root_ff[ROOT_W-1:1];
   assign result.normal = nrm_ff;

endmodule

// ===== src/area_weighted_cdf_sampler.sv =====
// Insert: cross product, squares, square root, three divisions and done in the geometry
//   unit, then a handover into the result registers.
// Sample: scale the fraction by the total in 16-bit slices, binary search, then fetch
//   and hand over the entry; an empty table answers without a search.
// One item at a time; the next is taken while a finished beat waits on rsp.
// Synchronous active-high reset empties the table and clears min_area.
module area_weighted_cdf_sampler
   import awcs_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
   input  logic                       clock,
   input  logic                       reset,
   // configuration
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [MINA_W-1:0]          csr_min_area,
   // request
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_mode,
   input  logic signed [COORD_W-1:0]  req_v0_x,
   input  logic signed [COORD_W-1:0]  req_v0_y,
   input  logic signed [COORD_W-1:0]  req_v0_z,
   input  logic signed [COORD_W-1:0]  req_v1_x,
   input  logic signed [COORD_W-1:0]  req_v1_y,
   input  logic signed [COORD_W-1:0]  req_v1_z,
   input  logic signed [COORD_W-1:0]  req_v2_x,
   input  logic signed [COORD_W-1:0]  req_v2_y,
   input  logic signed [COORD_W-1:0]  req_v2_z,
   input  logic [15:0]                req_random_fraction,
   // response
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [INDEX_W-1:0]         rsp_entry_index,
   output logic [CUM_W-1:0]           rsp_cumulative_area,
   output logic signed [15:0]         rsp_normal_x,
   output logic signed [15:0]         rsp_normal_y,
   output logic signed [15:0]         rsp_normal_z,
   output logic [CUM_W-1:0]           rsp_area_sum
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   top_state_type state_ff, state_in;

   logic [MINA_W-1:0] min_area_ff;
   logic [CW-1:0]     count_ff;
   logic [CUM_W-1:0]  total_ff;
   logic [15:0]       frac_ff;
   logic [63:0]       dart_ff;
   logic [1:0]        chunk_ff;
   logic [CW-1:0]     lo_ff, hi_ff, mid_ff;

   status_type        res_status_ff;
   logic [IW-1:0]     res_index_ff;
   logic [CUM_W-1:0]  res_cum_ff;
   logic [NRM_W-1:0]  res_nrm_ff;
   logic [CUM_W-1:0]  res_total_ff;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [IW-1:0]     rsp_index_ff;
   logic [CUM_W-1:0]  rsp_cum_ff;
   logic [NRM_W-1:0]  rsp_nrm_ff;
   logic [CUM_W-1:0]  rsp_total_ff;

   // table memories
   logic [CUM_W-1:0]  cum_mem [TABLE_DEPTH];
   logic [NRM_W-1:0]  nrm_mem [TABLE_DEPTH];
   logic [CUM_W-1:0]  cum_rd_ff;
   logic [NRM_W-1:0]  nrm_rd_ff;

   tri_type           tri_in;
   geom_res_type      geom;
   logic              geom_start;
   logic              mem_we;
   logic [IW-1:0]     rd_addr;
   logic              req_fire;
   logic              out_free;
   logic              table_full;
   logic              area_small;
   logic [CUM_W:0]    cum_sum;
   logic [CUM_W-1:0]  cum_new;
   logic [CW-1:0]     mid;
   logic [CW-1:0]     fin_idx;
   logic              search_on;
   logic [31:0]       dart_prod;
   logic [63:0]       dart_add;
   logic [15:0]       tot_chunk;

   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign table_full = (count_ff == CW'(TABLE_DEPTH));
   assign area_small = ({1'b0, geom.area} <= min_area_ff);
   assign cum_sum    = {1'b0, total_ff} + (CUM_W+1)'(geom.area);
   assign cum_new    = cum_sum[CUM_W] ? '1 : cum_sum[CUM_W-1:0];
   assign search_on  = (lo_ff < hi_ff);
   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign fin_idx    = (lo_ff >= count_ff) ? count_ff - CW'(1) : lo_ff;

   assign tri_in = '{v0_x: req_v0_x, v0_y: req_v0_y, v0_z: req_v0_z,
                     v1_x: req_v1_x, v1_y: req_v1_y, v1_z: req_v1_z,
                     v2_x: req_v2_x, v2_y: req_v2_y, v2_z: req_v2_z};

   awcs_geom u_geom (
      .clock  (clock),
      .reset  (reset),
      .start  (geom_start),
      .tri_in (tri_in),
      .result (geom)
   );

   // dart = fraction * total, one 16-bit slice of the total per cycle
   always_comb begin
      unique case (chunk_ff)
         2'd0:    tot_chunk = total_ff[15:0];
         2'd1:    tot_chunk = total_ff[31:16];
         default: tot_chunk = total_ff[47:32];
      endcase
   end
   assign dart_prod = frac_ff * tot_chunk;
   always_comb begin
      unique case (chunk_ff)
         2'd0:    dart_add = 64'(dart_prod);
         2'd1:    dart_add = 64'(dart_prod) << 16;
         default: dart_add = 64'(dart_prod) << 32;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (req_fire) begin
               if (req_mode == MODE_INSERT) state_in = T_GEOM;
               else if (count_ff == '0)     state_in = T_OUT;
               else                         state_in = T_DART;
            end
         end
         T_GEOM:    if (geom.done) state_in = T_OUT;
         T_DART:    if (chunk_ff == 2'd2) state_in = T_SEARCH;
         T_SEARCH:  state_in = search_on ? T_COMPARE : T_LOAD;
         T_COMPARE: state_in = T_SEARCH;
         T_LOAD:    state_in = T_OUT;
         T_OUT:     if (out_free) state_in = T_IDLE;
         default:   state_in = T_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_ready  = (state_ff == T_IDLE);
      geom_start = (state_ff == T_IDLE) && req_fire && (req_mode == MODE_INSERT);
      mem_we     = (state_ff == T_GEOM) && geom.done && !area_small && !table_full;
      rd_addr    = search_on ? IW'(mid) : IW'(fin_idx);
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         min_area_ff  <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) min_area_ff <= csr_min_area;
         if (mem_we) begin
            count_ff <= count_ff + CW'(1);
            total_ff <= cum_new;
         end
         if (state_ff == T_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)                rsp_valid_ff <= 1'b0;
      end
   end

   // Memories: one write port for inserts, registered read for the search
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cum_mem[IW'(count_ff)] <= cum_new;
         nrm_mem[IW'(count_ff)] <= geom.normal;
      end
      cum_rd_ff <= cum_mem[rd_addr];
      nrm_rd_ff <= nrm_mem[rd_addr];
   end

   // Item datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         T_IDLE: begin
            frac_ff  <= req_random_fraction;
            dart_ff  <= '0;
            chunk_ff <= '0;
            lo_ff    <= '0;
            hi_ff    <= count_ff;
            // empty table answer
            res_status_ff <= ST_EMPTY;
            res_index_ff  <= '0;
            res_cum_ff    <= '0;
            res_nrm_ff    <= '0;
            res_total_ff  <= '0;
         end
         T_GEOM: begin
            if (geom.done) begin
               if (area_small || table_full) begin
                  res_status_ff <= area_small ? ST_SKIPPED : ST_FULL;
                  res_index_ff  <= '0;
                  res_cum_ff    <= '0;
                  res_nrm_ff    <= '0;
                  res_total_ff  <= total_ff;
               end else begin
                  res_status_ff <= ST_INSERTED;
                  res_index_ff  <= IW'(count_ff);
                  res_cum_ff    <= cum_new;
                  res_nrm_ff    <= geom.normal;
                  res_total_ff  <= cum_new;
               end
            end
         end
         T_DART: begin
            dart_ff  <= dart_ff + dart_add;
            chunk_ff <= chunk_ff + 2'd1;
         end
         T_SEARCH: begin
            mid_ff <= mid;
         end
         T_COMPARE: begin
            // lower bound on cumulative * 2^16 >= dart
            if ({cum_rd_ff, 16'd0} < dart_ff) lo_ff <= mid_ff + CW'(1);
            else                              hi_ff <= mid_ff;
         end
         T_LOAD: begin
            res_status_ff <= ST_SAMPLED;
            res_index_ff  <= IW'(fin_idx);
            res_cum_ff    <= cum_rd_ff;
            res_nrm_ff    <= nrm_rd_ff;
            res_total_ff  <= total_ff;
         end
         default: begin
            if (out_free) begin
               rsp_status_ff <= res_status_ff;
               rsp_index_ff  <= res_index_ff;
               rsp_cum_ff    <= res_cum_ff;
               rsp_nrm_ff    <= res_nrm_ff;
               rsp_total_ff  <= res_total_ff;
            end
         end
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_entry_index     = INDEX_W'(rsp_index_ff);
   assign rsp_cumulative_area = rsp_cum_ff;
   assign rsp_normal_x        = rsp_nrm_ff[15:0];
   assign rsp_normal_y        = rsp_nrm_ff[31:16];
   assign rsp_normal_z        = rsp_nrm_ff[47:32];
   assign rsp_area_sum        = rsp_total_ff;

endmodule

// ===== src/awcs_checker.sv =====
// Port-level checks for area_weighted_cdf_sampler, bound to the top level.
// Uses awcs_pkg for widths and status codes.
module awcs_checker
   import awcs_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       csr_valid,
   input logic                       csr_ready,
   input logic [MINA_W-1:0]          csr_min_area,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_mode,
   input logic signed [COORD_W-1:0]  req_v0_x,
   input logic signed [COORD_W-1:0]  req_v0_y,
   input logic signed [COORD_W-1:0]  req_v0_z,
   input logic signed [COORD_W-1:0]  req_v1_x,
   input logic signed [COORD_W-1:0]  req_v1_y,
   input logic signed [COORD_W-1:0]  req_v1_z,
   input logic signed [COORD_W-1:0]  req_v2_x,
   input logic signed [COORD_W-1:0]  req_v2_y,
   input logic signed [COORD_W-1:0]  req_v2_z,
   input logic [15:0]                req_random_fraction,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [STATUS_W-1:0]        rsp_status,
   input logic [INDEX_W-1:0]         rsp_entry_index,
   input logic [CUM_W-1:0]           rsp_cumulative_area,
   input logic signed [15:0]         rsp_normal_x,
   input logic signed [15:0]         rsp_normal_y,
   input logic signed [15:0]         rsp_normal_z,
   input logic [CUM_W-1:0]           rsp_area_sum
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_cumulative_area))
      else $error("response beat changed while stalled");

   // an inserted entry becomes the new total
   a_ins_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INSERTED |-> rsp_cumulative_area == rsp_area_sum)
      else $error("inserted cumulative area differs from total");

   // an empty table answers with zero index, cumulative area and total
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_area_sum == '0
         && rsp_entry_index == '0 && rsp_cumulative_area == '0)
      else $error("empty-table beat carries data");

   // skipped or full leaves cumulative area and normal at zero
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_SKIPPED || rsp_status == ST_FULL)
         |-> rsp_cumulative_area == '0 && rsp_normal_x == '0
             && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("rejected triangle beat carries entry data");

endmodule

bind area_weighted_cdf_sampler awcs_checker u_awcs_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking bench for area_weighted_cdf_sampler: triangle inserts and CDF samples.
// Depends on awcs_pkg (status codes, modes, tri_type) and the sampler RTL.
module tb_top;
   import awcs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH     = 1024;
   localparam int WDOG_MAX  = 4000;
   localparam int HOLD_AT   = 6000;
   localparam int HOLD_LEN  = 500;

   typedef struct packed {
      logic        mode;
      tri_type     vtx;
      logic [15:0] fraction;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [9:0]  index;
      logic [47:0] cum;
      logic [15:0] nx;
      logic [15:0] ny;
      logic [15:0] nz;
      logic [47:0] total;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [35:0] csr_min_area = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   item_type    req_item = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [9:0]  rsp_entry_index;
   logic [47:0] rsp_cumulative_area;
   logic signed [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [47:0] rsp_area_sum;

   item_type   pending[$];
   result_type area_expect[$];
   int         fail_count = 0;

   // predictor state
   logic [47:0] cum_tab[DEPTH];
   logic [47:0] nrm_tab[DEPTH];
   int          n_entries = 0;
   logic [35:0] min_area_q = '0;

   area_weighted_cdf_sampler dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_min_area(csr_min_area),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_item.mode),
      .req_v0_x(req_item.vtx.v0_x), .req_v0_y(req_item.vtx.v0_y),
      .req_v0_z(req_item.vtx.v0_z), .req_v1_x(req_item.vtx.v1_x),
      .req_v1_y(req_item.vtx.v1_y), .req_v1_z(req_item.vtx.v1_z),
      .req_v2_x(req_item.vtx.v2_x), .req_v2_y(req_item.vtx.v2_y),
      .req_v2_z(req_item.vtx.v2_z), .req_random_fraction(req_item.fraction),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_entry_index(rsp_entry_index), .rsp_cumulative_area(rsp_cumulative_area),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_area_sum(rsp_area_sum)
   );

   // clock, period 4 ns
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // idle cycles between beats, often none
   function automatic int idle_draw();
      return ($urandom_range(2) == 0) ? int'($urandom_range(19)) : 0;
   endfunction

   // one Q1.15 normal component, rounded half away from zero and saturated
   function automatic logic [15:0] unit_comp(longint cv, logic [63:0] len);
      logic [63:0] mag, q;
      mag = (cv < 0) ? 64'(-cv) : 64'(cv);
      q   = (mag * 64'd32768 + (len >> 1)) / len;
      if (cv < 0)
         return (q > 64'd32768) ? 16'h8000 : 16'(-q);
      return (q > 64'd32767) ? 16'h7fff : 16'(q);
   endfunction

   // exact square of a cross product component
   function automatic logic [127:0] sq_mag(longint v);
      logic [127:0] m;
      m = 128'((v < 0) ? -v : v);
      return m * m;
   endfunction

   // expected beat for one item; updates the table on insert
   function automatic result_type table_step(item_type it);
      longint      e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
      logic [127:0] sq;
      logic [63:0] root, cand, area, tot, cum, dart;
      int          lo, hi, mid;
      result_type  r;
      r = '0;
      tot = (n_entries > 0) ? 64'(cum_tab[n_entries-1]) : 64'd0;
      r.total = tot[47:0];
      if (it.mode == MODE_INSERT) begin
         e1x = longint'(it.vtx.v1_x) - longint'(it.vtx.v0_x);
         e1y = longint'(it.vtx.v1_y) - longint'(it.vtx.v0_y);
         e1z = longint'(it.vtx.v1_z) - longint'(it.vtx.v0_z);
         e2x = longint'(it.vtx.v2_x) - longint'(it.vtx.v0_x);
         e2y = longint'(it.vtx.v2_y) - longint'(it.vtx.v0_y);
         e2z = longint'(it.vtx.v2_z) - longint'(it.vtx.v0_z);
         cx = e1y * e2z - e1z * e2y;
         cy = e1z * e2x - e1x * e2z;
         cz = e1x * e2y - e1y * e2x;
         sq = sq_mag(cx) + sq_mag(cy) + sq_mag(cz);
         root = '0;
         for (int b = 36; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= sq)
               root = cand;
         end
         area = root >> 1;
         if (area <= 64'(min_area_q)) begin
            r.status = ST_SKIPPED;
         end else if (n_entries >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            cum = tot + area;
            if (cum > 64'hffff_ffff_ffff)
               cum = 64'hffff_ffff_ffff;
            r.status = ST_INSERTED;
            r.index  = 10'(n_entries);
            r.cum    = cum[47:0];
            r.total  = cum[47:0];
            r.nx     = unit_comp(cx, root);
            r.ny     = unit_comp(cy, root);
            r.nz     = unit_comp(cz, root);
            cum_tab[n_entries] = cum[47:0];
            nrm_tab[n_entries] = {r.nz, r.ny, r.nx};
            n_entries++;
         end
      end else begin
         if (n_entries == 0) begin
            r.status = ST_EMPTY;
         end else begin
            // lower bound on the scaled cumulative areas
            dart = 64'(it.fraction) * tot;
            lo = 0;
            hi = n_entries;
            while (lo < hi) begin
               mid = lo + (hi - lo) / 2;
               if ({cum_tab[mid], 16'h0} < dart)
                  lo = mid + 1;
               else
                  hi = mid;
            end
            if (lo >= n_entries)
               lo = n_entries - 1;
            r.status = ST_SAMPLED;
            r.index  = 10'(lo);
            r.cum    = cum_tab[lo];
            {r.nz, r.ny, r.nx} = nrm_tab[lo];
         end
      end
      return r;
   endfunction

   task automatic push_item(item_type it);
      pending     = {pending, it};
      area_expect = {area_expect, table_step(it)};
   endtask

   function automatic tri_type make_tri(int a0x, int a0y, int a0z, int a1x, int a1y,
                                        int a1z, int a2x, int a2y, int a2z);
      tri_type t;
      t.v0_x = 16'(a0x); t.v0_y = 16'(a0y); t.v0_z = 16'(a0z);
      t.v1_x = 16'(a1x); t.v1_y = 16'(a1y); t.v1_z = 16'(a1z);
      t.v2_x = 16'(a2x); t.v2_y = 16'(a2y); t.v2_z = 16'(a2z);
      return t;
   endfunction

   task automatic push_tri(tri_type t);
      item_type it;
      it.mode = MODE_INSERT;
      it.vtx = t;
      it.fraction = 16'($urandom);
      push_item(it);
   endtask

   task automatic push_sample(logic [15:0] f);
      item_type it;
      it.mode = MODE_SAMPLE;
      it.vtx = tri_type'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      it.fraction = f;
      push_item(it);
   endtask

   // random triangle: full range, small, collinear or repeated vertex
   function automatic tri_type rand_tri();
      int k, bx, by, bz, dx, dy, dz, sp;
      k  = $urandom_range(9);
      sp = (k < 3) ? 32767 : 2000;
      bx = int'($urandom_range(2 * sp)) - sp;
      by = int'($urandom_range(2 * sp)) - sp;
      bz = int'($urandom_range(2 * sp)) - sp;
      dx = int'($urandom_range(200)) - 100;
      dy = int'($urandom_range(200)) - 100;
      dz = int'($urandom_range(200)) - 100;
      if (k < 2)
         return tri_type'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      if (k == 8)
         return make_tri(bx, by, bz, bx + dx, by + dy, bz + dz,
                         bx + 2 * dx, by + 2 * dy, bz + 2 * dz);
      if (k == 9)
         return make_tri(bx, by, bz, bx + dx, by + dy, bz + dz, bx, by, bz);
      return make_tri(bx, by, bz,
                      bx + int'($urandom_range(2000)) - 1000,
                      by + int'($urandom_range(2000)) - 1000,
                      bz + int'($urandom_range(2000)) - 1000,
                      bx + int'($urandom_range(2000)) - 1000,
                      by + int'($urandom_range(2000)) - 1000,
                      bz + int'($urandom_range(2000)) - 1000);
   endfunction

   task automatic push_random(int count, int insert_pct);
      for (int i = 0; i < count; i++) begin
         if (int'($urandom_range(99)) < insert_pct)
            push_tri(rand_tri());
         else
            push_sample(16'($urandom));
      end
   endtask

   // threshold write, only once the block has drained
   task automatic write_min_area(logic [35:0] v);
      while (pending.size() != 0 || area_expect.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid    <= 1'b1;
      csr_min_area <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      min_area_q = v;
   endtask

   // request driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= idle_draw();
      end else if (req_valid && !req_ready) begin
         // hold the beat
      end else if (req_gap != 0) begin
         req_valid <= 1'b0;
         req_gap   <= req_gap - 1;
      end else if (pending.size() != 0) begin
         req_item  <= pending.pop_front();
         req_valid <= 1'b1;
         req_gap   <= idle_draw();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // long receiver hold-off, so the block backs up into its input
   int cyc = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         cyc       <= 0;
         hold_left <= 0;
      end else begin
         cyc <= cyc + 1;
         if (cyc == HOLD_AT)
            hold_left <= HOLD_LEN;
         else if (hold_left > 0)
            hold_left <= hold_left - 1;
      end
   end

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // response monitor and ready control
   int out_wait = 0;
   always @(posedge clock) begin
      int w;
      result_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         out_wait  <= 0;
      end else begin
         w = (out_wait > 0) ? out_wait - 1 : 0;
         if (rsp_valid && rsp_ready) begin
            w = idle_draw();
            if (area_expect.size() == 0) begin
               $error("unexpected response beat, status %0d", rsp_status);
               fail_count++;
            end else begin
               e = area_expect.pop_front();
               check_field("status", 64'(e.status), 64'(rsp_status));
               check_field("entry_index", 64'(e.index), 64'(rsp_entry_index));
               check_field("cumulative_area", 64'(e.cum), 64'(rsp_cumulative_area));
               check_field("normal_x", 64'(e.nx), 64'(rsp_normal_x[15:0]));
               check_field("normal_y", 64'(e.ny), 64'(rsp_normal_y[15:0]));
               check_field("normal_z", 64'(e.nz), 64'(rsp_normal_z[15:0]));
               check_field("area_sum", 64'(e.total), 64'(rsp_area_sum));
            end
         end
         out_wait  <= w;
         rsp_ready <= (w == 0) && (hold_left == 0);
      end
   end

   // watchdog on cycles without any beat
   int stuck = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stuck <= 0;
      else
         stuck <= stuck + 1;
      if (stuck >= WDOG_MAX) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // stimulus
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_min_area(36'd0);
      push_sample(16'h0000);                                  // empty table
      push_tri(make_tri(5, 6, 7, 5, 6, 7, 5, 6, 7));          // all vertices equal
      push_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));          // root 1, area rounds to 0
      push_tri(make_tri(0, 0, 0, 2, 0, 0, 0, 1, 0));          // smallest accepted area
      push_tri(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                        -32768, 32767, -32768));
      push_tri(make_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                        32767, -32768, 32767));
      push_tri(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                        32767, 32767, -32768));
      push_tri(make_tri(10, 20, 30, 110, 120, 130, 210, 220, 230));  // collinear
      push_tri(make_tri(0, 0, 0, 0, 3, 0, 0, 0, -7));
      push_sample(16'h0000);
      push_sample(16'hffff);
      push_sample(16'h8000);
      push_sample(16'h0001);

      write_min_area(36'hf_ffff_ffff);                        // everything skipped
      push_tri(make_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                        32767, -32768, 32767));
      push_sample(16'h7fff);

      write_min_area(36'd1);
      push_tri(make_tri(0, 0, 0, 2, 0, 0, 0, 1, 0));          // area at threshold
      push_tri(make_tri(0, 0, 0, 4, 0, 0, 0, 1, 0));          // just above it
      push_sample(16'hffff);

      // random phases over several thresholds
      write_min_area(36'd0);
      push_random(120, 80);
      write_min_area(36'($urandom_range(200000)));
      push_random(120, 80);
      write_min_area({4'($urandom), 32'($urandom)});
      push_random(60, 70);
      write_min_area(36'($urandom_range(50)));
      push_random(120, 85);

      // fill the table, then overflow it
      write_min_area(36'd0);
      while (n_entries < DEPTH)
         push_tri(make_tri(0, 0, 0, int'($urandom_range(1, 3000)), 0, 0,
                           int'($urandom_range(3000)) - 1500,
                           int'($urandom_range(1, 3000)),
                           int'($urandom_range(3000)) - 1500));
      push_random(60, 50);

      while (pending.size() != 0 || area_expect.size() != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
